/* hdl/bsm_pkg.sv */
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants of the bounding sphere merge unit
// widths of the fixed-point formats, command and status words between the
// controller and the datapath
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // word formats
  localparam int unsigned CW    = 32;   // coordinate, signed q16.16
  localparam int unsigned RW    = 31;   // radius, unsigned q15.16
  localparam int unsigned PW    = 35;   // pole coordinate, signed
  localparam int unsigned DW    = 36;   // difference of two poles, signed
  localparam int unsigned MW    = 36;   // multiplier operand
  localparam int unsigned PRW   = 72;   // product and sum of squares
  localparam int unsigned RTW   = 36;   // square root
  localparam int unsigned QW    = 32;   // quotient of the offset division
  localparam int unsigned NUMW  = 64;   // dividend of the offset division
  localparam int unsigned RSQW  = 62;   // squared radius
  localparam int unsigned IDW   = 232;  // input word width
  localparam int unsigned ODW   = 136;  // output word width

  // item kinds
  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_MERGE = 2'd1;
  localparam logic [1:0] MODE_TEST  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic [2:0][CW-1:0] vec3_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SET_POLES,
    OP_DIFF_PT,
    OP_DIFF_POLE,
    OP_MUL_DSQ,
    OP_ACC,
    OP_MUL_RDIFF,
    OP_TAKE_IN,
    OP_SQRT,
    OP_DIST,
    OP_RADIUS,
    OP_MUL_RSQ,
    OP_SET_RSQ,
    OP_MUL_ALB,
    OP_MUL_ALI,
    OP_DIV,
    OP_P1,
    OP_P2,
    OP_TEST,
    OP_CLR_INSIDE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       sqrt_done;
    logic       div_done;
    logic       cont_held;
    logic       cont_in;
    logic       acc_zero;
    logic       out_busy;
  } stat_t;

endpackage

`default_nettype wire

/* hdl/bsm_sqrt.sv */
// ----------------------------------------------------------------------------
// bsm_sqrt: iterative integer square root
// floor root of a 72-bit value, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_sqrt import bsm_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [PRW-1:0] radicand,
  output logic      [RTW-1:0] root,
  output logic                done
);

  localparam int unsigned CNTW = $clog2(RTW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [PRW-1:0]  val;
  logic [RTW+2:0]  rem;
  logic [RTW-1:0]  rt;
  logic [RTW+2:0]  r2;
  logic [RTW+2:0]  trial;
  logic            ge;

  assign r2    = {rem[RTW:0], val[PRW-1 -: 2]};
  assign trial = {1'b0, rt, 2'b01};
  assign ge    = (r2 >= trial);
  assign root  = rt;
  assign done  = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      val  <= radicand;
      rem  <= '0;
      rt   <= '0;
    end else if (busy) begin
      val <= {val[PRW-3:0], 2'b00};
      rem <= ge ? (r2 - trial) : r2;
      rt  <= {rt[RTW-2:0], ge};
      if (cnt == CNTW'(RTW - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/bsm_div.sv */
// ----------------------------------------------------------------------------
// bsm_div: iterative divider for the centre line offsets
// restoring division, one quotient bit per cycle, rounded half up
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_div import bsm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NUMW-1:0] num,
  input  wire logic [RTW-1:0]  den,
  output logic      [QW-1:0]   quo,
  output logic                 done
);

  localparam int unsigned CNTW = $clog2(QW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [RTW-1:0]  rem;
  logic [RTW-1:0]  d_r;
  logic [QW-1:0]   nlo;
  logic [QW-1:0]   q;
  logic [RTW:0]    r2;
  logic            ge;
  logic            rnd;

  assign r2   = {rem, nlo[QW-1]};
  assign ge   = (r2 >= {1'b0, d_r});
  // remainder at least half the divisor rounds up
  assign rnd  = ({rem, 1'b0} >= {1'b0, d_r});
  assign quo  = q + QW'(rnd);
  assign done = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= RTW'(num[NUMW-1:QW]);
      nlo  <= num[QW-1:0];
      d_r  <= den;
      q    <= '0;
    end else if (busy) begin
      rem <= ge ? RTW'(r2 - {1'b0, d_r}) : r2[RTW-1:0];
      nlo <= {nlo[QW-2:0], 1'b0};
      q   <= {q[QW-2:0], ge};
      if (cnt == CNTW'(QW - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/bsm_dp.sv */
// ----------------------------------------------------------------------------
// bsm_dp: datapath of the bounding sphere merge unit
// held sphere, pole and difference registers, shared multiplier, root and
// divider units, output register
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_dp import bsm_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire logic [1:0]     load_mode,
  input  wire vec3_t          load_a,
  input  wire vec3_t          load_b,
  input  wire logic [RW-1:0]  load_radius,
  input  wire logic [1:0]     load_axis,
  input  wire cmd_t           cmd,
  input  wire logic           out_fire,
  output stat_t               stat,
  output logic                out_valid,
  output vec3_t               out_center,
  output logic      [RW-1:0]  out_radius,
  output logic      [1:0]     out_axis,
  output logic                out_inside
);

  // latched item
  logic [1:0]    mode_r;
  vec3_t         a_r;
  vec3_t         b_r;
  logic [RW-1:0] inr_r;
  logic [1:0]    inax_r;

  // held sphere
  vec3_t           cen;
  logic [RW-1:0]   hr;
  logic [RSQW-1:0] hrsq;
  logic [1:0]      hax;
  logic            pt_in;

  // work registers
  logic signed [PW-1:0] p [3];
  logic signed [PW-1:0] q [3];
  logic signed [DW-1:0] d [3];
  logic [PRW-1:0]       acc;
  logic [PRW-1:0]       prod;
  logic [RTW-1:0]       cdist;

  logic signed [DW-1:0] pqd [3];
  logic signed [DW-1:0] pqs [3];
  logic [DW-1:0]        pqa [3];
  logic signed [DW-1:0] md  [3];
  logic [CW-1:0]        mid [3];
  logic [DW-1:0]        abs_d;
  logic [DW-1:0]        best;
  logic [1:0]           axis;
  logic [RW-1:0]        rdiff;
  logic [MW-1:0]        mul_a;
  logic [MW-1:0]        mul_b;
  logic [PRW-1:0]       mul_p;
  logic [RTW-1:0]       root;
  logic                 sqrt_done;
  logic [QW-1:0]        quo;
  logic                 div_done;
  logic signed [PW-1:0] salong;
  logic signed [PW-1:0] cext;
  logic signed [PW-1:0] aext;

  function automatic logic [CW-1:0] sat_coord(input logic [DW-2:0] v);
    logic [CW-1:0] r;
    if ((&v[DW-2:CW-1]) || ~(|v[DW-2:CW-1])) begin
      r = v[CW-1:0];
    end else begin
      r = v[DW-2] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pqd[i] = DW'(p[i]) - DW'(q[i]);
      pqs[i] = DW'(p[i]) + DW'(q[i]);
      pqa[i] = pqd[i][DW-1] ? DW'(-pqd[i]) : DW'(pqd[i]);
      mid[i] = sat_coord(pqs[i][DW-1:1]);
      md[i]  = DW'($signed(a_r[i])) - DW'($signed(cen[i]));
    end
  end

  // longest pole axis, lower axis wins a tie
  always_comb begin
    if (pqa[0] < pqa[1]) begin
      best = pqa[1];
      axis = AXIS_Y;
    end else begin
      best = pqa[0];
      axis = AXIS_X;
    end
    if (best < pqa[2]) begin
      axis = AXIS_Z;
    end
  end

  assign abs_d = d[cmd.idx][DW-1] ? DW'(-d[cmd.idx]) : DW'(d[cmd.idx]);
  assign rdiff = (hr > inr_r) ? (hr - inr_r) : (inr_r - hr);

  always_comb begin
    mul_a = MW'(abs_d);
    mul_b = MW'(abs_d);
    case (cmd.op)
      OP_MUL_RDIFF: begin
        mul_a = MW'(rdiff);
        mul_b = MW'(rdiff);
      end
      OP_MUL_RSQ: begin
        mul_a = MW'(hr);
        mul_b = MW'(hr);
      end
      OP_MUL_ALB: mul_b = MW'(hr);
      OP_MUL_ALI: mul_b = MW'(inr_r);
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // signed offset along the centre line
  assign salong = d[cmd.idx][DW-1] ? -PW'(quo) : PW'(quo);
  assign cext   = PW'($signed(cen[cmd.idx]));
  assign aext   = PW'($signed(a_r[cmd.idx]));

  bsm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_SQRT),
    .radicand (acc),
    .root     (root),
    .done     (sqrt_done)
  );

  bsm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIV),
    .num   (prod[NUMW-1:0]),
    .den   (cdist),
    .quo   (quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= load_mode;
      a_r    <= load_a;
      b_r    <= load_b;
      inr_r  <= load_radius;
      inax_r <= load_axis;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cen       <= '0;
      hr        <= '0;
      hrsq      <= '0;
      hax       <= AXIS_X;
      pt_in     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_NONE: ;
        OP_SET_POLES: begin
          for (int i = 0; i < 3; i++) begin
            p[i] <= PW'($signed(a_r[i]));
            q[i] <= PW'($signed(b_r[i]));
          end
          pt_in <= 1'b0;
        end
        OP_DIFF_PT: begin
          for (int i = 0; i < 3; i++) d[i] <= md[i];
          acc   <= '0;
          pt_in <= 1'b0;
        end
        OP_DIFF_POLE: begin
          for (int i = 0; i < 3; i++) begin
            d[i]   <= pqd[i];
            cen[i] <= mid[i];
          end
          hax <= axis;
          acc <= '0;
        end
        OP_MUL_DSQ, OP_MUL_RDIFF, OP_MUL_RSQ, OP_MUL_ALB, OP_MUL_ALI: prod <= mul_p;
        OP_ACC:    acc <= acc + prod;
        OP_TAKE_IN: begin
          cen <= a_r;
          hr  <= inr_r;
          hax <= (inax_r == MODE_NONE) ? AXIS_Z : inax_r;
        end
        OP_SQRT:   ;
        OP_DIST:   cdist <= root;
        OP_RADIUS: hr <= (|root[RTW-1:RW+1]) ? {RW{1'b1}} : root[RW:1];
        OP_SET_RSQ: hrsq <= prod[RSQW-1:0];
        OP_DIV:    ;
        OP_P1: begin
          for (int i = 0; i < 3; i++) begin
            if (cmd.idx == 2'(i)) p[i] <= cext - salong;
          end
        end
        OP_P2: begin
          for (int i = 0; i < 3; i++) begin
            if (cmd.idx == 2'(i)) q[i] <= aext + salong;
          end
        end
        OP_TEST:       pt_in <= (acc <= PRW'(hrsq));
        OP_CLR_INSIDE: pt_in <= 1'b0;
        OP_EMIT: begin
          out_valid  <= 1'b1;
          out_center <= cen;
          out_radius <= hr;
          out_axis   <= hax;
          out_inside <= pt_in;
        end
        default: ;
      endcase
    end
  end

  assign stat.mode      = mode_r;
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign stat.cont_held = (hr > inr_r) && (acc < prod);
  assign stat.cont_in   = (inr_r > hr) && (acc < prod);
  assign stat.acc_zero  = (acc == '0);
  assign stat.out_busy  = out_valid;

endmodule

`default_nettype wire

/* hdl/bsm_ctrl.sv */
// ----------------------------------------------------------------------------
// bsm_ctrl: sequencer of the bounding sphere merge unit
// steps the datapath through set, merge and test with registered commands
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_ctrl import bsm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_fire,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       idle
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_PDIFF, S_SQ_MUL, S_SQ_ACC, S_SQ_END,
    S_SQRT_GAP, S_SQRT_WAIT, S_RSQ, S_RSQ_SET, S_CONT_GAP, S_CONT,
    S_AL_MUL, S_AL_DIV, S_AL_GAP, S_AL_WAIT, S_FINISH, S_OUT
  } state_t;

  typedef enum logic [1:0] {R_POLES, R_MERGE, R_TEST} ret_t;

  state_t     state;
  ret_t       ret;
  logic [1:0] idx;
  logic       sub;

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= R_POLES;
      idx     <= '0;
      sub     <= 1'b0;
      cmd.op  <= OP_NONE;
      cmd.idx <= '0;
    end else begin
      cmd.op  <= OP_NONE;
      cmd.idx <= idx;
      unique case (state)
        S_IDLE: if (in_fire) state <= S_DISPATCH;
        S_DISPATCH: begin
          case (stat.mode)
            MODE_SET: begin
              cmd.op <= OP_SET_POLES;
              state  <= S_PDIFF;
            end
            MODE_MERGE: begin
              cmd.op <= OP_DIFF_PT;
              ret    <= R_MERGE;
              idx    <= '0;
              state  <= S_SQ_MUL;
            end
            MODE_TEST: begin
              cmd.op <= OP_DIFF_PT;
              ret    <= R_TEST;
              idx    <= '0;
              state  <= S_SQ_MUL;
            end
            default: begin
              cmd.op <= OP_CLR_INSIDE;
              state  <= S_FINISH;
            end
          endcase
        end
        S_PDIFF: begin
          cmd.op <= OP_DIFF_POLE;
          ret    <= R_POLES;
          idx    <= '0;
          state  <= S_SQ_MUL;
        end
        S_SQ_MUL: begin
          cmd.op <= OP_MUL_DSQ;
          state  <= S_SQ_ACC;
        end
        S_SQ_ACC: begin
          cmd.op <= OP_ACC;
          if (idx == 2'd2) begin
            state <= S_SQ_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SQ_MUL;
          end
        end
        S_SQ_END: begin
          unique case (ret)
            R_TEST: begin
              cmd.op <= OP_TEST;
              state  <= S_FINISH;
            end
            R_MERGE: begin
              cmd.op <= OP_MUL_RDIFF;
              state  <= S_CONT_GAP;
            end
            default: begin
              cmd.op <= OP_SQRT;
              state  <= S_SQRT_GAP;
            end
          endcase
        end
        S_SQRT_GAP: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (stat.sqrt_done) begin
            if (ret == R_MERGE) begin
              cmd.op <= OP_DIST;
              idx    <= '0;
              sub    <= 1'b0;
              state  <= S_AL_MUL;
            end else begin
              cmd.op <= OP_RADIUS;
              state  <= S_RSQ;
            end
          end
        end
        S_RSQ: begin
          cmd.op <= OP_MUL_RSQ;
          state  <= S_RSQ_SET;
        end
        S_RSQ_SET: begin
          cmd.op <= OP_SET_RSQ;
          state  <= S_FINISH;
        end
        S_CONT_GAP: state <= S_CONT;
        S_CONT: begin
          if (stat.cont_held) begin
            state <= S_FINISH;
          end else if (stat.cont_in) begin
            cmd.op <= OP_TAKE_IN;
            state  <= S_RSQ;
          end else if (stat.acc_zero) begin
            state <= S_FINISH;
          end else begin
            cmd.op <= OP_SQRT;
            state  <= S_SQRT_GAP;
          end
        end
        S_AL_MUL: begin
          cmd.op <= sub ? OP_MUL_ALI : OP_MUL_ALB;
          state  <= S_AL_DIV;
        end
        S_AL_DIV: begin
          cmd.op <= OP_DIV;
          state  <= S_AL_GAP;
        end
        S_AL_GAP: state <= S_AL_WAIT;
        S_AL_WAIT: begin
          if (stat.div_done) begin
            cmd.op <= sub ? OP_P2 : OP_P1;
            if (!sub) begin
              sub   <= 1'b1;
              state <= S_AL_MUL;
            end else begin
              sub <= 1'b0;
              if (idx == 2'd2) begin
                state <= S_PDIFF;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_AL_MUL;
              end
            end
          end
        end
        S_FINISH: state <= S_OUT;
        S_OUT: begin
          if (!stat.out_busy) begin
            cmd.op <= OP_EMIT;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/bounding_sphere_merge.sv */
// throughput: one item at a time; the shared root unit (one bit a cycle over
//   36 bits) and the offset divider (one bit a cycle over 32 bits) set the time
// reset: synchronous, clears the held sphere to zero at once, no clearing pass
// ----------------------------------------------------------------------------
// bounding_sphere_merge: keeps one bounding sphere in q16.16
// sets it from two poles, merges an incoming sphere, tests a point
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_sphere_merge import bsm_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  // input word
  input  wire logic           s_tvalid,
  output logic                s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, in_radius, in_long_axis, zero pad
  input  wire logic [IDW-1:0] s_tdata,
  // mode
  input  wire logic [1:0]     s_tuser,
  // output word
  output logic                m_tvalid,
  input  wire logic           m_tready,
  // out_center_x, out_center_y, out_center_z, out_radius, out_long_axis,
  // point_inside, zero pad
  output logic      [ODW-1:0] m_tdata
);

  cmd_t          cmd;
  stat_t         stat;
  logic          idle;
  logic          in_fire;
  logic          out_fire;
  vec3_t         in_a;
  vec3_t         in_b;
  vec3_t         out_center;
  logic [RW-1:0] out_radius;
  logic [1:0]    out_axis;
  logic          out_inside;

  // a new word is taken only while the sequencer waits; a finished word may
  // still sit in the output register meanwhile
  assign s_tready = idle;
  assign in_fire  = s_tvalid & s_tready;
  assign out_fire = m_tvalid & m_tready;

  // unpack the input word, first field lowest
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_tdata[CW*i +: CW];
      in_b[i] = s_tdata[CW*(i+3) +: CW];
    end
  end

  bsm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .stat    (stat),
    .cmd     (cmd),
    .idle    (idle)
  );

  bsm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .load        (in_fire),
    .load_mode   (s_tuser),
    .load_a      (in_a),
    .load_b      (in_b),
    .load_radius (s_tdata[6*CW +: RW]),
    .load_axis   (s_tdata[6*CW+RW +: 2]),
    .cmd         (cmd),
    .out_fire    (out_fire),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_center  (out_center),
    .out_radius  (out_radius),
    .out_axis    (out_axis),
    .out_inside  (out_inside)
  );

  // pack the output word, first field lowest
  assign m_tdata = {{(ODW-3*CW-RW-3){1'b0}}, out_inside, out_axis, out_radius,
                    out_center[2], out_center[1], out_center[0]};

endmodule

`default_nettype wire

/* sim/bounding_sphere_merge_test.sv */
// ----------------------------------------------------------------------------
// bounding_sphere_merge_test: self-checking bench of the bounding sphere unit
// drives set, merge, point-test and ignored words with random gaps, predicts each
// output word from its own model of the held sphere and checks it field by field
// ----------------------------------------------------------------------------
`default_nettype none

// scoreboard: keeps a copy of the held sphere and the queue of expected words
class sphere_board;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint RMAXV = 64'sd2147483647;

  longint cx, cy, cz;
  longint unsigned rad, rad_sq;
  logic [1:0] axis;
  logic [135:0] expected_words[$];
  int errors;
  int checked;

  function new();
    cx = 0; cy = 0; cz = 0; rad = 0; rad_sq = 0; axis = 0;
    errors = 0; checked = 0;
  endfunction

  static function longint unsigned uabs(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  static function longint sat(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  static function longint halve(longint s);
    return s >>> 1;
  endfunction

  static function logic [127:0] dsq(longint d0, longint d1, longint d2);
    logic [127:0] a0, a1, a2;
    a0 = uabs(d0); a1 = uabs(d1); a2 = uabs(d2);
    return a0 * a0 + a1 * a1 + a2 * a2;
  endfunction

  static function longint unsigned isqrt(logic [127:0] v);
    logic [63:0] r, t;
    logic [127:0] tt;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      tt = {64'd0, t} * {64'd0, t};
      if (tt <= v) r = t;
    end
    return r;
  endfunction

  // offset along the centre line, rounded half away from zero
  static function longint offset(longint delta, longint unsigned len,
                                 longint unsigned den);
    logic [127:0] num, q, rm;
    if (den == 0) return 0;
    num = {64'd0, uabs(delta)} * {64'd0, len};
    q = num / den;
    rm = num % den;
    if (rm >= den - rm) q = q + 1;
    return (delta < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function void set_radius(longint unsigned r);
    logic [127:0] sq;
    if (r > RMAXV) r = RMAXV;
    rad = r;
    sq = {64'd0, r} * {64'd0, r};
    rad_sq = (sq[127:64] != 0) ? 64'hffff_ffff_ffff_ffff : sq[63:0];
  endfunction

  function void from_poles(longint p[3], longint q[3]);
    longint d[3];
    longint unsigned best;
    cx = sat(halve(p[0] + q[0]));
    cy = sat(halve(p[1] + q[1]));
    cz = sat(halve(p[2] + q[2]));
    for (int i = 0; i < 3; i++) d[i] = p[i] - q[i];
    set_radius(isqrt(dsq(d[0], d[1], d[2])) >> 1);
    axis = bsm_pkg::AXIS_X;
    best = uabs(d[0]);
    if (best < uabs(d[1])) begin
      best = uabs(d[1]);
      axis = bsm_pkg::AXIS_Y;
    end
    if (best < uabs(d[2])) axis = bsm_pkg::AXIS_Z;
  endfunction

  function void merge_in(longint o[3], longint unsigned r, logic [1:0] ax);
    longint c[3], d[3], p1[3], p2[3];
    longint unsigned big, cdist;
    logic [127:0] d2, lim;
    big = rad;
    c[0] = cx; c[1] = cy; c[2] = cz;
    for (int i = 0; i < 3; i++) d[i] = o[i] - c[i];
    d2 = dsq(d[0], d[1], d[2]);
    lim = {64'd0, big - r} * {64'd0, big - r};
    if (big > r && d2 < lim) return;
    lim = {64'd0, r - big} * {64'd0, r - big};
    if (r > big && d2 < lim) begin
      cx = o[0]; cy = o[1]; cz = o[2];
      set_radius(r);
      axis = (ax > 2) ? bsm_pkg::AXIS_Z : ax;
      return;
    end
    if (d2 == 0) return;
    cdist = isqrt(d2);
    for (int i = 0; i < 3; i++) begin
      p1[i] = c[i] - offset(d[i], big, cdist);
      p2[i] = o[i] + offset(d[i], r, cdist);
    end
    from_poles(p1, p2);
  endfunction

  // note an accepted input word and queue the word it must produce
  function void note_input(logic [1:0] mode, logic [231:0] w);
    longint a[3], b[3];
    logic pt_in;
    pt_in = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(w[32*i +: 32]));
      b[i] = longint'($signed(w[96 + 32*i +: 32]));
    end
    case (mode)
      bsm_pkg::MODE_SET: from_poles(a, b);
      bsm_pkg::MODE_MERGE: merge_in(a, longint'(w[222:192]), w[224:223]);
      bsm_pkg::MODE_TEST: begin
        pt_in = (dsq(a[0] - cx, a[1] - cy, a[2] - cz) <= {64'd0, rad_sq});
      end
      default: ;
    endcase
    expected_words.push_back({pt_in, axis, rad[30:0], cz[31:0], cy[31:0], cx[31:0]});
  endfunction

  function void check_output(logic [135:0] got);
    logic [135:0] e;
    checked++;
    if (expected_words.size() == 0) begin
      $display("%0t: output word with nothing expected: %h", $time, got);
      errors++;
      return;
    end
    e = expected_words.pop_front();
    for (int f = 0; f < 6; f++) begin
      int lo, wd;
      lo = (f < 3) ? 32*f : (f == 3) ? 96 : (f == 4) ? 127 : 129;
      wd = (f < 3) ? 32 : (f == 3) ? 31 : (f == 4) ? 2 : 1;
      if (((e >> lo) ^ (got >> lo)) & ((136'd1 << wd) - 1)) begin
        $display("%0t: field %0d expected %h actual %h", $time, f,
                 (e >> lo) & ((136'd1 << wd) - 1), (got >> lo) & ((136'd1 << wd) - 1));
        errors++;
      end
    end
  endfunction
endclass

module bounding_sphere_merge_test;
  import bsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 450;
  localparam int STALL_LIMIT = 4000; // longest merge plus both stalls, several times

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [IDW-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [ODW-1:0] m_tdata;

  sphere_board board;
  int idle_cycles;
  int sent;

  bounding_sphere_merge u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // random coordinate: mostly modest values so merges stay in range, some extremes
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2, 3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 7))
      0: return 31'($urandom());
      1: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'd0;
      2: return 31'($urandom_range(0, 1000));
      default: return 31'($urandom_range(0, 32'h0040_0000));
    endcase
  endfunction

  // send one input word, with a random gap before it
  task automatic send_word(logic [1:0] mode, logic [31:0] ax, ay, az, bx, by, bz,
                           logic [30:0] r, logic [1:0] la);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {7'd0, la, r, bz, by, bx, az, ay, ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(mode, {7'd0, la, r, bz, by, bx, az, ay, ax});
    sent++;
  endtask

  task automatic send_random();
    logic [1:0] mode;
    int pick;
    pick = $urandom_range(0, 19);
    mode = (pick < 6) ? MODE_SET : (pick < 13) ? MODE_MERGE : (pick < 19) ? MODE_TEST
           : MODE_NONE;
    send_word(mode, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_radius(), 2'($urandom()));
  endtask

  // output side: random stalls, check every accepted word
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.check_output(m_tdata);
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("bounding_sphere_merge_test failed");
      $finish;
    end
  end

  initial begin
    board = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_SET;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: test on the reset sphere, point at centre is inside (boundary)
    send_word(MODE_TEST, 0, 0, 0, 0, 0, 0, 0, AXIS_X);
    send_word(MODE_TEST, 1, 0, 0, 0, 0, 0, 0, AXIS_X);
    // poles at the coordinate extremes, saturating radius
    send_word(MODE_SET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, AXIS_X);
    send_word(MODE_TEST, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0, AXIS_X);
    // odd negative sum for midpoint rounding, ties on axis
    send_word(MODE_SET, -32'sd3, 32'sd4, 32'sd4, 32'sd0, 32'sd0, 32'sd0, 0, AXIS_X);
    send_word(MODE_SET, 0, 0, 0, 0, 0, 100, 0, AXIS_X);
    send_word(MODE_SET, 0, 0, 0, 0, 100, 0, 0, AXIS_X);
    // boundary point: sphere radius 50 around (0,50,0)
    send_word(MODE_TEST, 0, 100, 0, 0, 0, 0, 0, AXIS_X);
    send_word(MODE_TEST, 0, 101, 0, 0, 0, 0, 0, AXIS_X);
    // merge: equal sphere keeps self, contained, containing, axis three, apart
    send_word(MODE_MERGE, 0, 50, 0, 0, 0, 0, 50, AXIS_Z);
    send_word(MODE_MERGE, 0, 52, 0, 0, 0, 0, 10, AXIS_X);
    send_word(MODE_MERGE, 0, 50, 3, 0, 0, 0, 500, 2'd3);
    send_word(MODE_MERGE, 2000, 0, 0, 0, 0, 0, 300, AXIS_Y);
    send_word(MODE_MERGE, 2000, 0, 0, 0, 0, 0, 31'h7fff_ffff, AXIS_X);
    send_word(MODE_MERGE, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0, AXIS_X);
    send_word(MODE_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff, 2'd3);
    send_word(MODE_SET, 0, 0, 0, 0, 0, 0, 0, AXIS_X);
    send_word(MODE_MERGE, 0, 0, 0, 0, 0, 0, 0, AXIS_X);
    send_word(MODE_MERGE, 10, -10, 7, 0, 0, 0, 0, AXIS_X);
    for (int i = 0; i < N_RANDOM; i++) send_random();
    s_tvalid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d words sent over set, merge, test and ignored kinds; %0d output words checked",
             sent, board.checked);
    if (board.errors == 0 && board.expected_words.size() == 0)
      $display("bounding_sphere_merge_test passed");
    else
      $display("bounding_sphere_merge_test failed");
    $finish;
  end
endmodule

`default_nettype wire
